### src/ising_metropolis_spin_update_assert.svh
// Assertion macros used by the checker of the spin update block.
`ifndef ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ISU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ISU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/isu_pkg.sv
// Shared types, constants and helpers of the Ising spin update block.
`default_nettype none

package isu_pkg;

    localparam int unsigned ROWS_DEFAULT = 256;
    localparam int unsigned COLS_DEFAULT = 512;

    typedef enum logic [1:0] {
        KIND_LOAD_FIELD = 2'd0,
        KIND_LOAD_SPIN  = 2'd1,
        KIND_TRIAL      = 2'd2,
        KIND_READ_SPIN  = 2'd3
    } t_kind;

    localparam logic [1:0] REG_BETA     = 2'd0;
    localparam logic [1:0] REG_COUPLING = 2'd1;
    localparam logic [1:0] REG_GAIN     = 2'd2;

    localparam logic [15:0] BETA_RESET     = 16'd2048;
    localparam logic [15:0] COUPLING_RESET = 16'd4096;
    localparam logic [15:0] GAIN_RESET     = 16'd205;

    typedef struct packed {
        logic [15:0] beta;
        logic [15:0] coupling;
        logic [15:0] gain;
    } t_cfg;

    // log2(e) in Q.16, ln2 in Q.30, one in Q.30
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    // floor(2^36/127)+1: exact quotient by 127 for values below 2^29
    localparam logic [29:0] RECIP_127 = 30'd541098243;
    // floor(2^32/k)+1 for k = 3 and 5
    localparam logic [31:0] RECIP_3   = 32'd1431655766;
    localparam logic [31:0] RECIP_5   = 32'd858993460;
    localparam logic [2:0]  EXP_TERMS = 3'd6;
    localparam logic [6:0]  SHIFT_LIMIT = 7'd31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_LOOK,
        S_REPLY,
        S_GATHER,
        S_GLAST,
        S_KICK,
        S_CALC
    } t_top_state;

    typedef enum logic [3:0] {
        A_IDLE,
        A_INNER,
        A_PROD,
        A_SCALE,
        A_SUM,
        A_DIV,
        A_ULN,
        A_HMUL,
        A_HDIV,
        A_THR
    } t_acc_state;

    // Reduce a 9-bit index modulo m by restoring subtraction of m shifted.
    function automatic logic [8:0] reduce_index(input logic [8:0] v, input int unsigned m);
        logic [21:0] acc;
        logic [21:0] step;
        acc = {13'd0, v};
        for (int s = 8; s >= 0; s--) begin
            step = 22'(m) << s;
            if (acc >= step) begin
                acc = acc - step;
            end
        end
        return acc[8:0];
    endfunction

endpackage

`default_nettype wire

### src/isu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module isu_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/isu_cfg.sv
// APB register file holding beta, coupling and field gain.
`default_nettype none

module isu_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output isu_pkg::t_cfg    o_cfg
);

    isu_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.beta     <= isu_pkg::BETA_RESET;
            r_cfg.coupling <= isu_pkg::COUPLING_RESET;
            r_cfg.gain     <= isu_pkg::GAIN_RESET;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                isu_pkg::REG_BETA:     r_cfg.beta     <= pwdata[15:0];
                isu_pkg::REG_COUPLING: r_cfg.coupling <= pwdata[15:0];
                isu_pkg::REG_GAIN:     r_cfg.gain     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            isu_pkg::REG_BETA:     prdata = {16'd0, r_cfg.beta};
            isu_pkg::REG_COUPLING: prdata = {16'd0, r_cfg.coupling};
            isu_pkg::REG_GAIN:     prdata = {16'd0, r_cfg.gain};
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/isu_accept.sv
// Multi-cycle Metropolis acceptance unit: energy product, exponent and draw compare.
`default_nettype none

module isu_accept (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_go,
    input  wire isu_pkg::t_cfg i_cfg,
    input  wire logic          i_spin,
    input  wire logic [2:0]    i_ones,
    input  wire logic [7:0]    i_field,
    input  wire logic [30:0]   i_draw,
    output logic               o_done,
    output logic               o_flip
);

    isu_pkg::t_acc_state r_state, n_state;

    logic               r_s;
    logic [2:0]         r_ones;
    logic [7:0]         r_field;
    logic [30:0]        r_draw;
    logic signed [26:0] r_inner;
    logic signed [44:0] r_p;
    logic [34:0]        r_ml, r_mh;
    logic [28:0]        r_q;
    logic [22:0]        r_t;
    logic [29:0]        r_u;
    logic [6:0]         r_n;
    logic [30:0]        r_hp;
    logic [30:0]        r_x;
    logic [2:0]         r_k;
    logic               r_done, r_flip;

    logic signed [4:0]  nsum;
    logic signed [20:0] jn;
    logic signed [23:0] mf;
    logic signed [26:0] n_inner;
    logic signed [16:0] beta_s;
    logic signed [43:0] bp;
    logic signed [44:0] bp2;
    logic [35:0]        pc;
    logic [52:0]        asum;
    logic [58:0]        dprod;
    logic [45:0]        uprod;
    logic [60:0]        hm;
    logic [62:0]        dm;
    logic [30:0]        hq;
    logic [30:0]        ps;
    logic [61:0]        wide;
    logic [31:0]        th;

    assign o_done = r_done;
    assign o_flip = r_flip;

    // Energy terms and exponent products
    always_comb begin
        nsum    = $signed({1'b0, r_ones, 1'b0}) - 5'sd4;
        jn      = $signed(i_cfg.coupling) * nsum;
        mf      = $signed(i_cfg.gain) * $signed(r_field);
        n_inner = (27'(jn) <<< 7) - 27'(jn) - 27'(mf);
        beta_s  = $signed({1'b0, i_cfg.beta});
        bp      = beta_s * r_inner;
        bp2     = $signed({bp, 1'b0});
        pc      = (r_p[44:36] != '0) ? '1 : r_p[35:0];
        asum    = {r_mh, 18'd0} + {18'd0, r_ml};
        dprod   = 59'(r_q) * 59'(isu_pkg::RECIP_127);
        uprod   = 46'(r_t[15:0]) * 46'(isu_pkg::LN2_Q30);
        hm      = 61'(r_u) * 61'(r_hp);
    end

    // Horner term divide by k
    always_comb begin
        dm = '0;
        unique case (r_k)
            3'd1: hq = r_x;
            3'd2: hq = r_x >> 1;
            3'd3: begin
                dm = 63'(r_x) * 63'(isu_pkg::RECIP_3);
                hq = dm[62:32];
            end
            3'd4: hq = r_x >> 2;
            3'd5: begin
                dm = 63'(r_x) * 63'(isu_pkg::RECIP_5);
                hq = dm[62:32];
            end
            3'd6: begin
                dm = 63'(r_x >> 1) * 63'(isu_pkg::RECIP_3);
                hq = dm[62:32];
            end
            default: hq = '0;
        endcase
    end

    // Threshold from the shifted series value
    always_comb begin
        ps   = r_hp >> r_n[4:0];
        wide = {ps, 31'd0} - {31'd0, ps};
        th   = (r_n >= isu_pkg::SHIFT_LIMIT) ? 32'd0 : wide[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isu_pkg::A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == isu_pkg::A_SCALE && r_p <= 45'sd0)
                    || (r_state == isu_pkg::A_THR);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            isu_pkg::A_IDLE: begin
                if (i_go) begin
                    r_s     <= i_spin;
                    r_ones  <= i_ones;
                    r_field <= i_field;
                    r_draw  <= i_draw;
                end
            end
            isu_pkg::A_INNER: r_inner <= n_inner;
            isu_pkg::A_PROD:  r_p <= r_s ? bp2 : -bp2;
            isu_pkg::A_SCALE: begin
                r_flip <= 1'b1;
                r_ml   <= 35'(pc[17:0]) * 35'(isu_pkg::LOG2E_Q16);
                r_mh   <= 35'(pc[35:18]) * 35'(isu_pkg::LOG2E_Q16);
            end
            isu_pkg::A_SUM: r_q <= asum[52:24];
            isu_pkg::A_DIV: r_t <= dprod[58:36];
            isu_pkg::A_ULN: begin
                r_n  <= r_t[22:16];
                r_u  <= uprod[45:16];
                r_hp <= isu_pkg::ONE_Q30;
                r_k  <= isu_pkg::EXP_TERMS;
            end
            isu_pkg::A_HMUL: r_x <= hm[60:30];
            isu_pkg::A_HDIV: begin
                r_hp <= isu_pkg::ONE_Q30 - hq;
                r_k  <= r_k - 3'd1;
            end
            isu_pkg::A_THR: r_flip <= (th >= {1'b0, r_draw});
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isu_pkg::A_IDLE:  if (i_go) n_state = isu_pkg::A_INNER;
            isu_pkg::A_INNER: n_state = isu_pkg::A_PROD;
            isu_pkg::A_PROD:  n_state = isu_pkg::A_SCALE;
            isu_pkg::A_SCALE: n_state = (r_p <= 45'sd0) ? isu_pkg::A_IDLE : isu_pkg::A_SUM;
            isu_pkg::A_SUM:   n_state = isu_pkg::A_DIV;
            isu_pkg::A_DIV:   n_state = isu_pkg::A_ULN;
            isu_pkg::A_ULN:   n_state = isu_pkg::A_HMUL;
            isu_pkg::A_HMUL:  n_state = isu_pkg::A_HDIV;
            isu_pkg::A_HDIV:  n_state = (r_k == 3'd1) ? isu_pkg::A_THR : isu_pkg::A_HMUL;
            isu_pkg::A_THR:   n_state = isu_pkg::A_IDLE;
            default:          n_state = isu_pkg::A_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/ising_metropolis_spin_update.sv
// Top level of the 2D Ising lattice Metropolis spin update block.
//
//  channel   handshake              payload
//  --------  ---------------------  --------------------------------------------
//  item in   start high, busy low   i_kind i_row i_col i_field_value
//                                   i_spin_value i_random_draw
//  result    o_valid, one cycle     o_spin o_flipped
//  config    APB write access       pwdata[15:0] to paddr[3:2] (0 beta,
//                                   1 coupling, 2 field gain); prdata reads back
//
//  A trial makes five serial spin reads through the single spin memory read port;
//  when the energy term is positive it then runs the six Horner steps of the exp
//  series, each a multiply state and a divide state.
//  Reset (synchronous, active low) clears control state and sets the three
//  registers to beta 0.5, J 1.0 and mu 0.05; lattice memories are not cleared.
//  Busy stays high from acceptance to the result strobe; the result receiver
//  cannot stall, so each result shows on the ports for exactly one cycle.
`default_nettype none

module ising_metropolis_spin_update #(
    parameter int unsigned ROWS = isu_pkg::ROWS_DEFAULT,
    parameter int unsigned COLS = isu_pkg::COLS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_row,
    input  wire logic [8:0]  i_col,
    input  wire logic [7:0]  i_field_value,
    input  wire logic        i_spin_value,
    input  wire logic [30:0] i_random_draw,
    output logic             o_valid,
    output logic             o_spin,
    output logic             o_flipped,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int unsigned SITES = ROWS * COLS;
    localparam int unsigned AW    = $clog2(SITES);
    localparam int unsigned RW    = $clog2(ROWS);
    localparam int unsigned CW    = $clog2(COLS);

    isu_pkg::t_top_state r_state, n_state;
    isu_pkg::t_kind      r_kind;
    isu_pkg::t_cfg       cfg;

    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [7:0]    r_fval;
    logic          r_sval;
    logic [30:0]   r_draw;
    logic [2:0]    r_idx;
    logic          r_pend;
    logic [2:0]    r_pend_idx;
    logic          r_s;
    logic [2:0]    r_ones;
    logic [7:0]    r_field;
    logic          r_valid;

    logic [RW-1:0] row_dn, row_up;
    logic [CW-1:0] col_rt, col_lf;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic [AW-1:0] center_addr, spin_raddr;
    logic          spin_we, spin_wdata, spin_rdata;
    logic          field_we;
    logic [7:0]    field_rdata;
    logic          go;
    logic          acc_done, acc_flip;
    logic          n_valid, n_spin, n_flipped;
    logic          accept;

    assign accept  = start && !busy;
    assign busy    = (r_state != isu_pkg::S_IDLE);
    assign o_valid = r_valid;

    // Wrapped neighbor coordinates
    assign row_dn = (r_row == RW'(ROWS - 1)) ? '0 : r_row + RW'(1);
    assign row_up = (r_row == '0) ? RW'(ROWS - 1) : r_row - RW'(1);
    assign col_rt = (r_col == CW'(COLS - 1)) ? '0 : r_col + CW'(1);
    assign col_lf = (r_col == '0) ? CW'(COLS - 1) : r_col - CW'(1);

    // Pick the site for the spin read: center, down, up, right, left.
    always_comb begin
        unique case (r_idx)
            3'd1:    begin rd_row = row_dn; rd_col = r_col;  end
            3'd2:    begin rd_row = row_up; rd_col = r_col;  end
            3'd3:    begin rd_row = r_row;  rd_col = col_rt; end
            3'd4:    begin rd_row = r_row;  rd_col = col_lf; end
            default: begin rd_row = r_row;  rd_col = r_col;  end
        endcase
    end

    assign center_addr = AW'(r_row) * AW'(COLS) + AW'(r_col);
    assign spin_raddr  = AW'(rd_row) * AW'(COLS) + AW'(rd_col);

    isu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    isu_ram #(.WIDTH(1), .DEPTH(SITES)) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (spin_we),
        .i_waddr (center_addr),
        .i_wdata (spin_wdata),
        .i_raddr (spin_raddr),
        .o_rdata (spin_rdata)
    );

    isu_ram #(.WIDTH(8), .DEPTH(SITES)) u_field_ram (
        .i_clk   (i_clk),
        .i_we    (field_we),
        .i_waddr (center_addr),
        .i_wdata (r_fval),
        .i_raddr (center_addr),
        .o_rdata (field_rdata)
    );

    isu_accept u_accept (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_cfg   (cfg),
        .i_spin  (r_s),
        .i_ones  (r_ones),
        .i_field (r_field),
        .i_draw  (r_draw),
        .o_done  (acc_done),
        .o_flip  (acc_flip)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= isu_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= (r_state == isu_pkg::S_GATHER);
        end
    end

    // Item fields, read capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= isu_pkg::t_kind'(i_kind);
            r_row  <= RW'(isu_pkg::reduce_index({1'b0, i_row}, ROWS));
            r_col  <= CW'(isu_pkg::reduce_index(i_col, COLS));
            r_fval <= i_field_value;
            r_sval <= i_spin_value;
            r_draw <= i_random_draw;
            r_idx  <= '0;
            r_ones <= '0;
        end else if (r_state == isu_pkg::S_GATHER) begin
            r_idx <= r_idx + 3'd1;
        end
        r_pend_idx <= r_idx;
        // Read data lands in the cycle after its address; tally neighbors as they land.
        if (r_pend) begin
            if (r_pend_idx == 3'd0) begin
                r_s     <= spin_rdata;
                r_field <= field_rdata;
            end else begin
                r_ones <= r_ones + {2'd0, spin_rdata};
            end
        end
        if (n_valid) begin
            o_spin    <= n_spin;
            o_flipped <= n_flipped;
        end
    end

    always_comb begin
        n_state    = r_state;
        spin_we    = 1'b0;
        spin_wdata = r_sval;
        field_we   = 1'b0;
        go         = 1'b0;
        n_valid    = 1'b0;
        n_spin     = spin_rdata;
        n_flipped  = 1'b0;
        unique case (r_state)
            isu_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (isu_pkg::t_kind'(i_kind))
                        isu_pkg::KIND_LOAD_SPIN: n_state = isu_pkg::S_WRITE;
                        isu_pkg::KIND_TRIAL:     n_state = isu_pkg::S_GATHER;
                        default:                 n_state = isu_pkg::S_LOOK;
                    endcase
                end
            end
            isu_pkg::S_WRITE: begin
                spin_we = 1'b1;
                n_valid = 1'b1;
                n_spin  = r_sval;
                n_state = isu_pkg::S_IDLE;
            end
            isu_pkg::S_LOOK: begin
                field_we = (r_kind == isu_pkg::KIND_LOAD_FIELD);
                n_state  = isu_pkg::S_REPLY;
            end
            isu_pkg::S_REPLY: begin
                n_valid = 1'b1;
                n_state = isu_pkg::S_IDLE;
            end
            isu_pkg::S_GATHER: begin
                if (r_idx == 3'd4) begin
                    n_state = isu_pkg::S_GLAST;
                end
            end
            isu_pkg::S_GLAST: n_state = isu_pkg::S_KICK;
            isu_pkg::S_KICK: begin
                go      = 1'b1;
                n_state = isu_pkg::S_CALC;
            end
            isu_pkg::S_CALC: begin
                if (acc_done) begin
                    // Write back the flipped spin and report.
                    spin_we    = acc_flip;
                    spin_wdata = !r_s;
                    n_valid    = 1'b1;
                    n_spin     = r_s ^ acc_flip;
                    n_flipped  = acc_flip;
                    n_state    = isu_pkg::S_IDLE;
                end
            end
            default: n_state = isu_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/isu_checker.sv
// Port-level checker for the spin update block, bound to the top level.
`default_nettype none
`include "ising_metropolis_spin_update_assert.svh"

module isu_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    `ISU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `ISU_ASSERT_SAME(a_result_idle, o_valid, !busy, "result shown while still busy")
    `ISU_ASSERT_NEXT(a_result_pulse, o_valid, !o_valid, "result held beyond one cycle")
    `ISU_ASSERT_NEXT(a_no_phantom, !busy && !o_valid, !o_valid, "result without an item")

endmodule

bind ising_metropolis_spin_update isu_checker u_isu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

`default_nettype wire
